[src/mrsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI running status parser package
// Event codes, the result record and status byte helpers.
// ----------------------------------------------------------------------------
package mrsp_pkg;

  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_CC       = 2'd2;

  // Upper nibbles of the channel-voice status bytes.
  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_POLY_AT   = 4'hA;
  localparam logic [3:0] NIB_CTRL      = 4'hB;
  localparam logic [3:0] NIB_PROG      = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRES = 4'hD;
  localparam logic [3:0] NIB_BEND      = 4'hE;
  localparam logic [3:0] NIB_SYSTEM    = 4'hF;

  localparam logic [7:0] NO_STATUS     = 8'h00;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] chan;
    logic [6:0] first_value;
    logic [6:0] second_value;
  } mrsp_evt_t;

  // Number of data bytes that follow a channel-voice status byte.
  function automatic logic [1:0] bytes_for_status(input logic [7:0] st);
    logic [1:0] n;
    unique case (st[7:4])
      NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_BEND: n = 2'd2;
      NIB_PROG, NIB_CHAN_PRES:                                     n = 2'd1;
      default:                                                     n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

[src/midi_running_status_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI running status parser
// Assembles note off, note on and control change events from a MIDI byte
// stream, with running status.
// ----------------------------------------------------------------------------
// The parser takes one MIDI byte per cycle while in_ready is high. Each
// accepted byte updates the stored status, data count and first data byte,
// and the byte that completes a note off, note on or control change message
// puts its event into the output register, or into the skid entry when the
// output register is stalled. Real-time bytes are skipped, system bytes
// cancel the running status, and a note on with zero velocity is reported as
// a note off. The output register has one skid entry behind it, so in_ready
// drops only when two events are waiting on a stalled result channel.
// ----------------------------------------------------------------------------
module midi_running_status_parser
  import mrsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [3:0] out_chan,
  output logic [6:0] out_first_value,
  output logic [6:0] out_second_value
);

  logic [7:0] status_r, status_nxt;
  logic [1:0] need_r, need_nxt;
  logic [1:0] held_r, held_nxt;
  logic [6:0] first_r, first_nxt;

  logic       accept;
  logic       is_realtime, is_status, is_system;
  logic [1:0] held_inc;
  logic       complete;
  logic       evt_vld;
  mrsp_evt_t  evt;
  mrsp_evt_t  out_evt;

  assign accept      = in_valid && in_ready;
  assign is_realtime = (in_rx_byte[7:3] == 5'b11111);
  assign is_status   = in_rx_byte[7];
  assign is_system   = (in_rx_byte[7:4] == NIB_SYSTEM);
  assign held_inc    = held_r + 2'd1;
  assign complete    = (held_inc >= need_r);

  always_comb begin
    status_nxt = status_r;
    need_nxt   = need_r;
    held_nxt   = held_r;
    first_nxt  = first_r;
    evt_vld    = 1'b0;
    evt.event_kind   = KIND_NOTE_OFF;
    evt.chan         = status_r[3:0];
    evt.first_value  = first_r;
    evt.second_value = in_rx_byte[6:0];
    if (accept && !is_realtime) begin
      if (is_status) begin
        if (is_system) begin
          status_nxt = NO_STATUS;
          need_nxt   = 2'd0;
        end else begin
          status_nxt = in_rx_byte;
          need_nxt   = bytes_for_status(in_rx_byte);
        end
        held_nxt = 2'd0;
      end else if (status_r != NO_STATUS) begin
        if (held_r == 2'd0) begin
          first_nxt = in_rx_byte[6:0];
        end
        if (complete) begin
          held_nxt = 2'd0;
          // Only two-byte messages report, so the second byte is this one.
          unique case (status_r[7:4])
            NIB_NOTE_ON: begin
              evt_vld        = 1'b1;
              evt.event_kind = (in_rx_byte[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            end
            NIB_NOTE_OFF: begin
              evt_vld        = 1'b1;
              evt.event_kind = KIND_NOTE_OFF;
            end
            NIB_CTRL: begin
              evt_vld        = 1'b1;
              evt.event_kind = KIND_CC;
            end
            default: begin
              evt_vld = 1'b0;
            end
          endcase
        end else begin
          held_nxt = held_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= NO_STATUS;
      need_r   <= 2'd0;
      held_r   <= 2'd0;
    end else begin
      status_r <= status_nxt;
      need_r   <= need_nxt;
      held_r   <= held_nxt;
    end
    first_r <= first_nxt;
  end

  mrsp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (evt_vld),
    .push_data (evt),
    .push_rdy  (in_ready),
    .out_vld   (out_valid),
    .out_data  (out_evt),
    .out_rdy   (out_ready)
  );

  assign out_event_kind   = out_evt.event_kind;
  assign out_chan         = out_evt.chan;
  assign out_first_value  = out_evt.first_value;
  assign out_second_value = out_evt.second_value;

  a_no_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == NO_STATUS) |-> (need_r == 2'd0 && held_r == 2'd0))
    else $error("data count is active without a running status");

  a_partial_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != 2'd0) |-> (need_r == 2'd2 && held_r == 2'd1))
    else $error("partial message count does not fit its status");

  a_orphan_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_rx_byte[7] && status_r == NO_STATUS) |=>
      (status_r == NO_STATUS && held_r == 2'd0))
    else $error("orphan data byte changed the parser state");

endmodule

[src/mrsp_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI running status parser output buffer
// Output register with one skid entry, so the parser keeps taking bytes
// while a finished event waits on the result channel.
// ----------------------------------------------------------------------------
module mrsp_out_buf
  import mrsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_vld,
  input  mrsp_evt_t push_data,
  output logic      push_rdy,
  output logic      out_vld,
  output mrsp_evt_t out_data,
  input  logic      out_rdy
);

  logic      out_vld_r, out_vld_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  mrsp_evt_t out_data_r, out_data_nxt;
  mrsp_evt_t skid_data_r, skid_data_nxt;
  logic      out_free;

  assign push_rdy = !skid_vld_r;
  assign out_free = !out_vld_r || out_rdy;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (out_free) begin
      if (skid_vld_r) begin
        // Drain the older item first; no push can arrive while skid is full.
        out_vld_nxt  = 1'b1;
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = push_vld;
        out_data_nxt = push_data;
      end
    end else if (push_vld) begin
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry holds an item while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_vld && skid_vld_r))
    else $error("item pushed while both buffer entries are full");

endmodule

[tb/midi_event_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI event checker
// Watches the byte and event channels of the running status parser. It keeps
// its own model of the parser, queues the event each accepted byte should
// produce, and compares every accepted event field by field with the oldest
// one in the queue.
// ----------------------------------------------------------------------------
module midi_event_checker
  import mrsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_event_kind,
  input  logic [3:0] out_chan,
  input  logic [6:0] out_first_value,
  input  logic [6:0] out_second_value,
  output int         n_errors,
  output int         n_pending,
  output int         n_note_off,
  output int         n_note_on,
  output int         n_cc
);

  // Parser state as seen by the model.
  logic [7:0] cur_status;
  logic [1:0] data_needed;
  logic [1:0] data_held;
  logic [6:0] data0;
  logic [6:0] data1;

  mrsp_evt_t expected_events[$];

  function automatic logic [1:0] data_length(input logic [3:0] nib);
    logic [1:0] len;
    case (nib)
      NIB_PROG, NIB_CHAN_PRES: len = 2'd1;
      NIB_SYSTEM:              len = 2'd0;
      default:                 len = 2'd2;
    endcase
    return len;
  endfunction

  // Updates the model with one byte; returns 1 when the byte completes an
  // event that the parser reports.
  function automatic bit parse_midi_byte(input logic [7:0] b, output mrsp_evt_t ev);
    ev = '0;
    // Real-time bytes leave everything untouched.
    if (b[7:4] == NIB_SYSTEM && b[3]) return 1'b0;
    if (b[7]) begin
      if (b[7:4] == NIB_SYSTEM) begin
        cur_status  = NO_STATUS;
        data_needed = 2'd0;
      end else begin
        cur_status  = b;
        data_needed = data_length(b[7:4]);
      end
      data_held = 2'd0;
      return 1'b0;
    end
    if (cur_status == NO_STATUS) return 1'b0;
    if (data_held == 2'd0) data0 = b[6:0];
    else data1 = b[6:0];
    data_held = data_held + 2'd1;
    if (data_held < data_needed) return 1'b0;
    data_held       = 2'd0;
    ev.chan         = cur_status[3:0];
    ev.first_value  = data0;
    ev.second_value = data1;
    case (cur_status[7:4])
      NIB_NOTE_ON:  ev.event_kind = (data1 == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
      NIB_NOTE_OFF: ev.event_kind = KIND_NOTE_OFF;
      NIB_CTRL:     ev.event_kind = KIND_CC;
      default:      return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_errors++;
    end
  endtask

  initial begin
    n_errors   = 0;
    n_pending  = 0;
    n_note_off = 0;
    n_note_on  = 0;
    n_cc       = 0;
  end

  always @(posedge clk) begin
    mrsp_evt_t ev;
    mrsp_evt_t want;
    if (!rst_n) begin
      cur_status  = NO_STATUS;
      data_needed = 2'd0;
      data_held   = 2'd0;
      data0       = 7'd0;
      data1       = 7'd0;
      expected_events.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (parse_midi_byte(in_rx_byte, ev)) expected_events.push_back(ev);
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("event kind %0d chan %0d arrived with nothing expected",
                 out_event_kind, out_chan);
          n_errors++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", int'(want.event_kind), int'(out_event_kind));
          check_field("chan", int'(want.chan), int'(out_chan));
          check_field("first_value", int'(want.first_value), int'(out_first_value));
          check_field("second_value", int'(want.second_value), int'(out_second_value));
          case (want.event_kind)
            KIND_NOTE_OFF: n_note_off++;
            KIND_NOTE_ON:  n_note_on++;
            default:       n_cc++;
          endcase
        end
      end
    end
    n_pending <= expected_events.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running status parser testbench
// Feeds MIDI byte streams to the parser: a directed opening, then mostly
// well-formed channel messages with running status, mixed with real-time
// bytes, system bytes, cut-off messages and raw noise, under several idle
// and stall mixes. The checker beside the block judges every event.
// ----------------------------------------------------------------------------
module tb
  import mrsp_pkg::*;
();

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 480;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_event_kind;
  logic [3:0] out_chan;
  logic [6:0] out_first_value;
  logic [6:0] out_second_value;

  int n_errors;
  int n_pending;
  int n_note_off;
  int n_note_on;
  int n_cc;

  int send_idle_pct;
  int recv_stall_pct;
  int bytes_sent;
  int quiet_cycles;
  bit hold_req;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  midi_running_status_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_chan         (out_chan),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value)
  );

  midi_event_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_chan         (out_chan),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value),
    .n_errors         (n_errors),
    .n_pending        (n_pending),
    .n_note_off       (n_note_off),
    .n_note_on        (n_note_on),
    .n_cc             (n_cc)
  );

  // Event sink. A hold request stalls it for a long stretch so the parser
  // fills up and pushes back on the byte channel.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] data_byte();
    return {1'b0, 7'($urandom_range(127))};
  endfunction

  function automatic logic [7:0] realtime_byte();
    return {NIB_SYSTEM, 1'b1, 3'($urandom_range(7))};
  endfunction

  function automatic logic [3:0] pick_voice();
    logic [3:0] nib;
    case ($urandom_range(8))
      0:       nib = NIB_NOTE_OFF;
      1, 2:    nib = NIB_NOTE_ON;
      3, 4:    nib = NIB_CTRL;
      5:       nib = NIB_POLY_AT;
      6:       nib = NIB_PROG;
      7:       nib = NIB_CHAN_PRES;
      default: nib = NIB_BEND;
    endcase
    return nib;
  endfunction

  // Offers one byte and returns at the edge where it is accepted.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // A status byte followed by several messages' worth of data under running
  // status, with the odd real-time byte slipped in before data bytes.
  task automatic put_message(input logic [3:0] nib, input logic [3:0] ch, input int reps);
    int len;
    len = (nib == NIB_PROG || nib == NIB_CHAN_PRES) ? 1 : 2;
    put_byte({nib, ch});
    for (int r = 0; r < reps; r++) begin
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(19) == 0) put_byte(realtime_byte());
        if (k == 1 && $urandom_range(5) == 0) put_byte(8'h00);
        else put_byte(data_byte());
      end
    end
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic random_run(input int target, input bit with_hold);
    int start;
    int pick;
    int n;
    bit held;
    start = bytes_sent;
    held  = 1'b0;
    while (bytes_sent - start < target) begin
      if (with_hold && !held && bytes_sent - start >= target / 2) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        put_message(pick_voice(), 4'($urandom_range(15)), $urandom_range(1, 4));
      end else if (pick < 80) begin
        // Cut-off message: for a two-byte type, the next status byte discards the partial data.
        put_byte({pick_voice(), 4'($urandom_range(15))});
        put_byte(data_byte());
      end else if (pick < 90) begin
        put_byte({NIB_SYSTEM, 1'b0, 3'($urandom_range(7))});
        n = $urandom_range(2);
        repeat (n) put_byte(data_byte());
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) put_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_byte     = 8'h00;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_sent     = 0;
    hold_req       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: orphan data, each channel message type at the
    // extremes, running status with a real-time byte inside, zero velocity,
    // a system byte cancelling the status, and a status arriving mid-message.
    put_byte(8'h7F);
    put_byte({NIB_NOTE_ON, 4'h0});
    put_byte(8'h3C);
    put_byte(8'h40);
    put_byte(8'h3D);
    put_byte({NIB_SYSTEM, 4'hF});
    put_byte(8'h00);
    put_byte({NIB_NOTE_OFF, 4'hF});
    put_byte(8'h7F);
    put_byte(8'h7F);
    put_byte({NIB_CTRL, 4'h5});
    put_byte(8'h07);
    put_byte(8'h64);
    put_byte({NIB_POLY_AT, 4'h2});
    put_byte(8'h11);
    put_byte(8'h22);
    put_byte({NIB_PROG, 4'h3});
    put_byte(8'h05);
    put_byte({NIB_CHAN_PRES, 4'h4});
    put_byte(8'h7F);
    put_byte({NIB_BEND, 4'h6});
    put_byte(8'h00);
    put_byte(8'h40);
    put_byte({NIB_SYSTEM, 4'h7});
    put_byte(8'h12);
    put_byte({NIB_NOTE_ON, 4'hA});
    put_byte(8'h10);
    put_byte({NIB_CTRL, 4'hB});
    put_byte(8'h01);
    put_byte(8'h02);
    drain_events();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      random_run(PHASE_ITEMS, phase == 0);
      // The sender waits here until every outstanding event has come out.
      drain_events();
    end
    repeat (8) @(posedge clk);

    $display("Summary: %0d bytes sent over four idle/stall mixes and one long sink hold-off.",
             bytes_sent);
    $display("Summary: events checked: %0d note off, %0d note on, %0d control change.",
             n_note_off, n_note_on, n_cc);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
src/mrsp_pkg.sv
src/mrsp_out_buf.sv
src/midi_running_status_parser.sv
tb/midi_event_checker.sv
tb/tb.sv
